@@ design/dvst_pkg.sv @@
// shared types and codes for the distinct value set table
package dvst_pkg;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_DUMP   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE        = 3'd0,
        ST_PRESENT     = 3'd1,
        ST_NOT_PRESENT = 3'd2,
        ST_FULL        = 3'd3,
        ST_EMPTY       = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } state_t;

    localparam logic [VALUE_W-1:0] SIGN_FLIP = {1'b1, {(VALUE_W-1){1'b0}}};

endpackage

@@ design/distinct_value_set_table.sv @@
// distinct value set table: insert, delete, search and sorted dump over a scanned table
// insert, delete and search: one output beat per input beat, after one full table scan
// dump: one full table scan per stored value, one output beat per scan
// dump of an empty table: one beat out, without a table scan
// not ready while a beat is in work: ready again in the cycle the last output beat is presented
// reset (async, active low) clears valid bits, the entry count and the handshake state
module distinct_value_set_table #(
    parameter int CAPACITY = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dvst_pkg::VALUE_W-1:0]   s_axis_tdata,   // value
    input  logic [dvst_pkg::ACTION_W-1:0]  s_axis_tuser,   // action
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [dvst_pkg::VALUE_W-1:0]   m_axis_tdata,   // value_out
    output logic [dvst_pkg::STATUS_W-1:0]  m_axis_tuser,   // status
    output logic                           m_axis_tlast    // last
);
    import dvst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    logic [VALUE_W-1:0] mem [CAPACITY];

    state_t              state_reg, state_next;
    action_t             action_reg, action_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    emitted_reg, emitted_next;

    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic                issue_reg, issue_next;
    logic [VALUE_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_vld_reg, rd_vld_next;

    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                free_reg, free_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                first_reg, first_next;
    logic                best_found_reg, best_found_next;
    logic [VALUE_W-1:0]  best_key_reg, best_key_next;
    logic [VALUE_W-1:0]  prev_key_reg, prev_key_next;

    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_data_reg, out_data_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_wa;
    logic                slot_valid;
    logic [VALUE_W-1:0]  rd_key;
    logic                out_free;
    logic                is_last;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    assign slot_valid = valid_reg[rd_idx_reg];
    assign rd_key     = rd_data_reg ^ SIGN_FLIP;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign is_last    = ((emitted_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        val_next        = val_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        emitted_next    = emitted_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        rd_vld_next     = 1'b0;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        first_next      = first_reg;
        best_found_next = best_found_reg;
        best_key_next   = best_key_reg;
        prev_key_next   = prev_key_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_wa          = free_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    action_next     = action_t'(s_axis_tuser);
                    val_next        = s_axis_tdata;
                    addr_next       = '0;
                    issue_next      = 1'b1;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    first_next      = 1'b1;
                    best_found_next = 1'b0;
                    emitted_next    = '0;
                    if (action_t'(s_axis_tuser) == ACT_DUMP && count_reg == '0)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // read stage
                if (issue_reg)
                begin
                    rd_vld_next = 1'b1;
                    if (addr_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = addr_reg + IDX_W'(1);
                    end
                end
                // compare stage
                if (rd_vld_reg)
                begin
                    if (action_reg == ACT_DUMP)
                    begin
                        if (slot_valid && (first_reg || rd_key > prev_key_reg)
                            && (!best_found_reg || rd_key < best_key_reg))
                        begin
                            best_found_next = 1'b1;
                            best_key_next   = rd_key;
                        end
                    end
                    else
                    begin
                        if (slot_valid && rd_data_reg == val_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = rd_idx_reg;
                        end
                        if (!slot_valid && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = rd_idx_reg;
                        end
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = S_RESULT;
                    end
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = val_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                    case (action_reg)
                        ACT_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                out_status_next = ST_PRESENT;
                            end
                            else if (free_reg)
                            begin
                                out_status_next          = ST_DONE;
                                mem_we                   = 1'b1;
                                valid_next[free_idx_reg] = 1'b1;
                                count_next               = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                out_status_next = ST_FULL;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (hit_reg)
                            begin
                                out_status_next         = ST_DONE;
                                valid_next[hit_idx_reg] = 1'b0;
                                count_next              = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                out_status_next = ST_NOT_PRESENT;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            out_status_next = hit_reg ? ST_DONE : ST_NOT_PRESENT;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = ST_EMPTY;
                                out_data_next   = '0;
                            end
                            else
                            begin
                                out_status_next = ST_DONE;
                                out_data_next   = best_key_reg ^ SIGN_FLIP;
                                out_last_next   = is_last;
                                if (!is_last)
                                begin
                                    // next pass: smallest value above this one
                                    emitted_next    = emitted_reg + CNT_W'(1);
                                    prev_key_next   = best_key_reg;
                                    first_next      = 1'b0;
                                    best_found_next = 1'b0;
                                    addr_next       = '0;
                                    issue_next      = 1'b1;
                                    state_next      = S_SCAN;
                                end
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        val_reg        <= val_next;
        emitted_reg    <= emitted_next;
        addr_reg       <= addr_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        first_reg      <= first_next;
        best_found_reg <= best_found_next;
        best_key_reg   <= best_key_next;
        prev_key_reg   <= prev_key_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // value memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= val_reg;
        end
        rd_data_reg <= mem[addr_reg];
        rd_idx_reg  <= addr_reg;
    end

endmodule
